/* design/lrc_pkg.sv */
// ----------------------------------------------------------------------------
// lrc_pkg: shared widths, constants and beam table
// Field widths, fixed-point formats and pipeline depths used by the lidar
// return to Cartesian point pipeline and its trig unit.
// ----------------------------------------------------------------------------
package lrc_pkg;

   // port field widths
   localparam int BEAM_W = 8;
   localparam int DIST_W = 16;
   localparam int AZ_W   = 16;
   localparam int POS_W  = 17;

   // angle widths: folded angle 0..4500, quarter remainder 0..8999, elevation 0..1500
   localparam int ANGLE_W = 13;
   localparam int REM_W   = 14;
   localparam int EL_W    = 11;

   localparam int AZ_QUARTER = 9000;
   localparam int AZ_EIGHTH  = 4500;

   // radian conversion: t = (a * PI_Q30 + RAD_BIAS) / RAD_DIV in Q30
   localparam longint PI_Q30   = 64'd3373259426;
   localparam int     RAD_DIV  = 18000;
   localparam int     RAD_BIAS = 9000;

   // Q30 series datapath
   localparam int Q_SHIFT = 30;
   localparam int T_W     = 30;
   localparam int TERM_W  = 31;
   localparam int SUM_W   = 32;

   localparam int SIN_TERMS    = 4;
   localparam int COS_TERMS    = 5;
   localparam int CELL_STAGES  = 3;
   localparam int FRONT_STAGES = 4;
   localparam int TRIG_LAT     = FRONT_STAGES + COS_TERMS * CELL_STAGES + 1;

   typedef struct packed {
      logic            neg;
      logic [EL_W-1:0] cdeg;
   } elev_type;

   // beam elevations in centidegrees, even beams point down
   localparam elev_type ELEV_TABLE [16] = '{
      '{1'b1, 11'd1500}, '{1'b0, 11'd100},
      '{1'b1, 11'd1300}, '{1'b0, 11'd300},
      '{1'b1, 11'd1100}, '{1'b0, 11'd500},
      '{1'b1, 11'd900},  '{1'b0, 11'd700},
      '{1'b1, 11'd700},  '{1'b0, 11'd900},
      '{1'b1, 11'd500},  '{1'b0, 11'd1100},
      '{1'b1, 11'd300},  '{1'b0, 11'd1300},
      '{1'b1, 11'd100},  '{1'b0, 11'd1500}
   };

endpackage

/* design/lrc_taylor_cell.sv */
// ----------------------------------------------------------------------------
// lrc_taylor_cell: one term of a Q30 power series
// Computes term' = ((term * t2) >> 30) / DIVISOR and adds or subtracts it
// from the running sum. Three register stages; t2 is handed to the next cell.
// ----------------------------------------------------------------------------
module lrc_taylor_cell #(
   parameter int DIVISOR  = 6,
   parameter bit SUBTRACT = 1'b1
) (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic        [lrc_pkg::T_W-1:0]       src_t2,
   input  logic        [lrc_pkg::TERM_W-1:0]    src_term,
   input  logic signed [lrc_pkg::SUM_W-1:0]     src_sum,
   output logic        [lrc_pkg::T_W-1:0]       dst_t2,
   output logic        [lrc_pkg::TERM_W-1:0]    dst_term,
   output logic signed [lrc_pkg::SUM_W-1:0]     dst_sum
);

   localparam int TERM_W      = lrc_pkg::TERM_W;
   localparam int T_W         = lrc_pkg::T_W;
   localparam int SUM_W       = lrc_pkg::SUM_W;
   localparam int DIV_W       = $clog2(DIVISOR + 1);
   localparam int EXT_W       = TERM_W + DIV_W;
   localparam int RECIP_SHIFT = TERM_W;
   localparam logic [TERM_W-1:0] RECIP = TERM_W'((64'd1 << RECIP_SHIFT) / DIVISOR);

   // stage A: Q30 product
   logic        [TERM_W+T_W-1:0] prod_a;
   logic        [TERM_W-1:0]     x_a_ff, x_a_in;
   logic        [T_W-1:0]        t2_a_ff;
   logic signed [SUM_W-1:0]      sum_a_ff;

   // stage B: reciprocal estimate
   logic        [2*TERM_W-1:0]   prod_b;
   logic        [TERM_W-1:0]     qe_ff, qe_in;
   logic        [TERM_W-1:0]     x_b_ff;
   logic        [T_W-1:0]        t2_b_ff;
   logic signed [SUM_W-1:0]      sum_b_ff;

   // stage C: correct quotient and accumulate
   logic        [EXT_W-1:0]      qd;
   logic        [EXT_W-1:0]      rem;
   logic                         fix;
   logic        [TERM_W-1:0]     term_c_ff, term_c_in;
   logic signed [SUM_W-1:0]      sum_c_ff, sum_c_in;
   logic        [T_W-1:0]        t2_c_ff;

   always_comb begin
      prod_a = src_term * src_t2;
      x_a_in = prod_a[lrc_pkg::Q_SHIFT +: TERM_W];
   end

   always_comb begin
      prod_b = x_a_ff * RECIP;
      qe_in  = prod_b[RECIP_SHIFT +: TERM_W];
   end

   // estimate is low by at most one
   always_comb begin
      qd        = qe_ff * DIV_W'(DIVISOR);
      rem       = {{DIV_W{1'b0}}, x_b_ff} - qd;
      fix       = (rem >= EXT_W'(DIVISOR));
      term_c_in = qe_ff + TERM_W'(fix);
      if (SUBTRACT) begin
         sum_c_in = sum_b_ff - signed'({1'b0, term_c_in});
      end else begin
         sum_c_in = sum_b_ff + signed'({1'b0, term_c_in});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_a_ff    <= x_a_in;
         t2_a_ff   <= src_t2;
         sum_a_ff  <= src_sum;
         qe_ff     <= qe_in;
         x_b_ff    <= x_a_ff;
         t2_b_ff   <= t2_a_ff;
         sum_b_ff  <= sum_a_ff;
         term_c_ff <= term_c_in;
         sum_c_ff  <= sum_c_in;
         t2_c_ff   <= t2_b_ff;
      end
   end

   assign dst_t2   = t2_c_ff;
   assign dst_term = term_c_ff;
   assign dst_sum  = sum_c_ff;

endmodule

/* design/lrc_trig.sv */
// ----------------------------------------------------------------------------
// lrc_trig: sine and cosine of an angle of 0..45 degrees
// Converts centidegrees to Q30 radians, runs the sine and cosine series
// through chains of Taylor cells and rounds both to FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module lrc_trig #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [lrc_pkg::ANGLE_W-1:0]   angle,
   output logic [FRAC_BITS:0]            sin_mag,
   output logic [FRAC_BITS:0]            cos_mag
);

   localparam int ANGLE_W     = lrc_pkg::ANGLE_W;
   localparam int T_W         = lrc_pkg::T_W;
   localparam int TERM_W      = lrc_pkg::TERM_W;
   localparam int SUM_W       = lrc_pkg::SUM_W;
   localparam int SIN_TERMS   = lrc_pkg::SIN_TERMS;
   localparam int COS_TERMS   = lrc_pkg::COS_TERMS;
   localparam int DLY_STAGES  = (COS_TERMS - SIN_TERMS) * lrc_pkg::CELL_STAGES;

   // a * PI = a * RAD_DIV * PI_QUO + a * PI_REM
   localparam longint PI_QUO      = lrc_pkg::PI_Q30 / lrc_pkg::RAD_DIV;
   localparam longint PI_REM      = lrc_pkg::PI_Q30 % lrc_pkg::RAD_DIV;
   localparam int     QUO_W       = 18;
   localparam int     LO_W        = 25;
   localparam int     QLO_W       = 11;
   localparam int     RECIP_W     = 26;
   localparam int     RECIP_SHIFT = 40;
   localparam longint RECIP       =
      ((longint'(1) << RECIP_SHIFT) + lrc_pkg::RAD_DIV - 1) / lrc_pkg::RAD_DIV;

   localparam logic signed [SUM_W-1:0] ONE_Q  = SUM_W'(64'd1 << lrc_pkg::Q_SHIFT);
   localparam logic        [SUM_W-1:0] HALF_F = SUM_W'(64'd1 << (29 - FRAC_BITS));

   function automatic logic [FRAC_BITS:0] round_mag(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-1:0] u;
      if (v < 0) begin
         u = '0;
      end else if (v > ONE_Q) begin
         u = ONE_Q;
      end else begin
         u = v;
      end
      u = u + HALF_F;
      return u[(lrc_pkg::Q_SHIFT - FRAC_BITS) +: (FRAC_BITS + 1)];
   endfunction

   logic [2*ANGLE_W-1:0]       lo_prod;
   logic [ANGLE_W+QUO_W-1:0]   aq_prod;
   logic [LO_W-1:0]            lo_ff, lo_in;
   logic [T_W-1:0]             aq_ff, aq_in;
   logic [LO_W+RECIP_W-1:0]    qlo_prod;
   logic [QLO_W-1:0]           qlo_ff, qlo_in;
   logic [T_W-1:0]             aq1_ff;
   logic [T_W-1:0]             t_ff, t_in;
   logic [2*T_W-1:0]           sq;
   logic [T_W-1:0]             t2_ff, t2_in;
   logic [T_W-1:0]             t3_ff;

   logic        [T_W-1:0]      cos_t2   [COS_TERMS+1];
   logic        [TERM_W-1:0]   cos_term [COS_TERMS+1];
   logic signed [SUM_W-1:0]    cos_sum  [COS_TERMS+1];
   logic        [T_W-1:0]      sin_t2   [SIN_TERMS+1];
   logic        [TERM_W-1:0]   sin_term [SIN_TERMS+1];
   logic signed [SUM_W-1:0]    sin_sum  [SIN_TERMS+1];

   logic signed [SUM_W-1:0]    sin_dly_ff [DLY_STAGES];
   logic        [FRAC_BITS:0]  sin_ff, sin_in;
   logic        [FRAC_BITS:0]  cos_ff, cos_in;

   always_comb begin
      lo_prod = angle * ANGLE_W'(PI_REM);
      aq_prod = angle * QUO_W'(PI_QUO);
      lo_in   = LO_W'(lo_prod + (2*ANGLE_W)'(lrc_pkg::RAD_BIAS));
      aq_in   = aq_prod[T_W-1:0];
   end

   always_comb begin
      qlo_prod = lo_ff * RECIP_W'(RECIP);
      qlo_in   = qlo_prod[RECIP_SHIFT +: QLO_W];
   end

   always_comb begin
      t_in  = aq1_ff + T_W'(qlo_ff);
      sq    = t_ff * t_ff;
      t2_in = sq[lrc_pkg::Q_SHIFT +: T_W];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff  <= lo_in;
         aq_ff  <= aq_in;
         qlo_ff <= qlo_in;
         aq1_ff <= aq_ff;
         t_ff   <= t_in;
         t2_ff  <= t2_in;
         t3_ff  <= t_ff;
      end
   end

   // series seeds: cosine starts at one, sine at t
   assign cos_t2[0]   = t2_ff;
   assign cos_term[0] = TERM_W'(64'd1 << lrc_pkg::Q_SHIFT);
   assign cos_sum[0]  = ONE_Q;
   assign sin_t2[0]   = t2_ff;
   assign sin_term[0] = TERM_W'(t3_ff);
   assign sin_sum[0]  = SUM_W'(t3_ff);

   for (genvar k = 0; k < COS_TERMS; k++) begin : g_cos
      lrc_taylor_cell #(
         .DIVISOR  ((2*k + 1) * (2*k + 2)),
         .SUBTRACT (k % 2 == 0)
      ) u_cell (
         .clock    (clock),
         .en       (en),
         .src_t2   (cos_t2[k]),
         .src_term (cos_term[k]),
         .src_sum  (cos_sum[k]),
         .dst_t2   (cos_t2[k+1]),
         .dst_term (cos_term[k+1]),
         .dst_sum  (cos_sum[k+1])
      );
   end

   for (genvar k = 0; k < SIN_TERMS; k++) begin : g_sin
      lrc_taylor_cell #(
         .DIVISOR  ((2*k + 2) * (2*k + 3)),
         .SUBTRACT (k % 2 == 0)
      ) u_cell (
         .clock    (clock),
         .en       (en),
         .src_t2   (sin_t2[k]),
         .src_term (sin_term[k]),
         .src_sum  (sin_sum[k]),
         .dst_t2   (sin_t2[k+1]),
         .dst_term (sin_term[k+1]),
         .dst_sum  (sin_sum[k+1])
      );
   end

   // hold the shorter sine chain until the cosine catches up
   always_ff @(posedge clock) begin
      if (en) begin
         sin_dly_ff[0] <= sin_sum[SIN_TERMS];
         for (int i = 1; i < DLY_STAGES; i++) begin
            sin_dly_ff[i] <= sin_dly_ff[i-1];
         end
      end
   end

   always_comb begin
      sin_in = round_mag(sin_dly_ff[DLY_STAGES-1]);
      cos_in = round_mag(cos_sum[COS_TERMS]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_mag = sin_ff;
   assign cos_mag = cos_ff;

endmodule

/* design/lidar_return_to_cartesian.sv */
// ----------------------------------------------------------------------------
// lidar_return_to_cartesian: 16-beam lidar return to x, y, z point
// Looks up the beam elevation, takes fixed-point sine and cosine of
// elevation and azimuth, and scales the range into a Cartesian point.
// ----------------------------------------------------------------------------
// The block takes one return per clock while no point is held on rsp_stall and
// delivers one point per return, in order, through angle folding (P1, P2), the
// trig unit (radian conversion, the five-cell cosine series chain and
// rounding), the range products (M1..M3) and one output register.
// The pipeline holds as a whole while a point waits on rsp_stall, and
// req_stall is raised for exactly those cycles.
module lidar_return_to_cartesian #(
   parameter int TRIG_FRACTION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic        [lrc_pkg::BEAM_W-1:0]   req_beam_index,
   input  logic        [lrc_pkg::DIST_W-1:0]   req_distance,
   input  logic        [lrc_pkg::AZ_W-1:0]     req_azimuth_cdeg,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [lrc_pkg::POS_W-1:0]    rsp_pos_x,
   output logic signed [lrc_pkg::POS_W-1:0]    rsp_pos_y,
   output logic signed [lrc_pkg::POS_W-1:0]    rsp_pos_z
);

   localparam int F         = TRIG_FRACTION_BITS;
   localparam int MAG_W     = F + 1;
   localparam int DIST_W    = lrc_pkg::DIST_W;
   localparam int AZ_W      = lrc_pkg::AZ_W;
   localparam int POS_W     = lrc_pkg::POS_W;
   localparam int ANGLE_W   = lrc_pkg::ANGLE_W;
   localparam int REM_W     = lrc_pkg::REM_W;
   localparam int EL_W      = lrc_pkg::EL_W;
   localparam int TRIG_LAT  = lrc_pkg::TRIG_LAT;
   localparam int RCE_W     = DIST_W + MAG_W;
   localparam int LO_W      = RCE_W / 2;
   localparam int HI_W      = RCE_W - LO_W;
   localparam int PLO_W     = LO_W + MAG_W;
   localparam int PHI_W     = HI_W + MAG_W;
   localparam int ACC_W     = RCE_W + MAG_W + 1;
   localparam int ZACC_W    = RCE_W + 1;

   typedef struct packed {
      logic eneg;
      logic sneg;
      logic cneg;
   } sign_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              swap;
      sign_type          sign;
   } side_type;

   logic en;

   // stage P1: split azimuth into quarter turns
   logic [2:0]          q8;
   logic [AZ_W-1:0]     base;
   lrc_pkg::elev_type   elev;
   logic                p1_vld_ff;
   logic [REM_W-1:0]    p1_rem_ff, p1_rem_in;
   logic [1:0]          p1_quad_ff;
   logic [EL_W-1:0]     p1_emag_ff;
   logic                p1_eneg_ff;
   logic [DIST_W-1:0]   p1_dist_ff;

   // stage P2: fold to the first octant
   logic                p2_vld_ff;
   logic [ANGLE_W-1:0]  p2_az_ff, p2_az_in;
   logic                fold;
   logic [EL_W-1:0]     p2_emag_ff;
   side_type            p2_side_ff, p2_side_in;

   // trig results and side line
   logic [MAG_W-1:0]    el_s, el_c, az_s, az_c;
   logic [TRIG_LAT-1:0] side_vld_ff;
   side_type            side_ff [TRIG_LAT];
   side_type            side_out;

   // stage M1..M3: range products
   logic                m1_vld_ff;
   logic [RCE_W-1:0]    m1_rce_ff, m1_rce_in;
   logic [RCE_W-1:0]    m1_rse_ff, m1_rse_in;
   logic [MAG_W-1:0]    m1_sa_ff, m1_sa_in;
   logic [MAG_W-1:0]    m1_ca_ff, m1_ca_in;
   sign_type            m1_sign_ff;

   logic                m2_vld_ff;
   logic [PLO_W-1:0]    m2_pxl_ff, m2_pxl_in, m2_pyl_ff, m2_pyl_in;
   logic [PHI_W-1:0]    m2_pxh_ff, m2_pxh_in, m2_pyh_ff, m2_pyh_in;
   logic [ZACC_W-1:0]   zacc;
   logic [POS_W-1:0]    m2_mz_ff, m2_mz_in;
   sign_type            m2_sign_ff;

   logic                m3_vld_ff;
   logic [ACC_W-1:0]    xacc, yacc;
   logic [POS_W-1:0]    m3_mx_ff, m3_mx_in, m3_my_ff, m3_my_in, m3_mz_ff;
   sign_type            m3_sign_ff;

   logic                     rsp_valid_ff;
   logic signed [POS_W-1:0]  rsp_pos_x_ff, rsp_pos_x_in;
   logic signed [POS_W-1:0]  rsp_pos_y_ff, rsp_pos_y_in;
   logic signed [POS_W-1:0]  rsp_pos_z_ff, rsp_pos_z_in;

   // freeze everything while a finished word is held
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // ---- P1 ----
   always_comb begin
      q8   = '0;
      base = '0;
      for (int k = 1; k < 8; k++) begin
         if (req_azimuth_cdeg >= AZ_W'(k * lrc_pkg::AZ_QUARTER)) begin
            q8   = 3'(k);
            base = AZ_W'(k * lrc_pkg::AZ_QUARTER);
         end
      end
      p1_rem_in = REM_W'(req_azimuth_cdeg - base);
      elev      = lrc_pkg::ELEV_TABLE[req_beam_index[3:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else if (en) begin
         p1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_rem_ff  <= p1_rem_in;
         p1_quad_ff <= q8[1:0];
         p1_emag_ff <= elev.cdeg;
         p1_eneg_ff <= elev.neg;
         p1_dist_ff <= req_distance;
      end
   end

   // ---- P2 ----
   always_comb begin
      fold = (p1_rem_ff > REM_W'(lrc_pkg::AZ_EIGHTH));
      if (fold) begin
         p2_az_in = ANGLE_W'(REM_W'(lrc_pkg::AZ_QUARTER) - p1_rem_ff);
      end else begin
         p2_az_in = ANGLE_W'(p1_rem_ff);
      end
      p2_side_in.distance  = p1_dist_ff;
      p2_side_in.swap      = fold ^ p1_quad_ff[0];
      p2_side_in.sign.eneg = p1_eneg_ff;
      p2_side_in.sign.sneg = p1_quad_ff[1];
      p2_side_in.sign.cneg = p1_quad_ff[1] ^ p1_quad_ff[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_vld_ff <= 1'b0;
      end else if (en) begin
         p2_vld_ff <= p1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p2_az_ff   <= p2_az_in;
         p2_emag_ff <= p1_emag_ff;
         p2_side_ff <= p2_side_in;
      end
   end

   // ---- trig ----
   lrc_trig #(.FRAC_BITS(F)) u_trig_el (
      .clock   (clock),
      .en      (en),
      .angle   (ANGLE_W'(p2_emag_ff)),
      .sin_mag (el_s),
      .cos_mag (el_c)
   );

   lrc_trig #(.FRAC_BITS(F)) u_trig_az (
      .clock   (clock),
      .en      (en),
      .angle   (p2_az_ff),
      .sin_mag (az_s),
      .cos_mag (az_c)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         side_vld_ff <= '0;
      end else if (en) begin
         side_vld_ff <= {side_vld_ff[TRIG_LAT-2:0], p2_vld_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= p2_side_ff;
         for (int i = 1; i < TRIG_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign side_out = side_ff[TRIG_LAT-1];

   // ---- M1: quadrant swap and range times elevation ----
   always_comb begin
      m1_sa_in  = side_out.swap ? az_c : az_s;
      m1_ca_in  = side_out.swap ? az_s : az_c;
      m1_rce_in = side_out.distance * el_c;
      m1_rse_in = side_out.distance * el_s;
   end

   // ---- M2: split products, finish z ----
   always_comb begin
      m2_pxl_in = m1_rce_ff[LO_W-1:0] * m1_sa_ff;
      m2_pxh_in = m1_rce_ff[RCE_W-1:LO_W] * m1_sa_ff;
      m2_pyl_in = m1_rce_ff[LO_W-1:0] * m1_ca_ff;
      m2_pyh_in = m1_rce_ff[RCE_W-1:LO_W] * m1_ca_ff;
      zacc      = ZACC_W'(m1_rse_ff) + (ZACC_W'(1) << (F - 1));
      m2_mz_in  = zacc[F +: POS_W];
   end

   // ---- M3: merge partials, round half up ----
   always_comb begin
      xacc     = (ACC_W'(m2_pxh_ff) << LO_W) + ACC_W'(m2_pxl_ff)
                 + (ACC_W'(1) << (2*F - 1));
      yacc     = (ACC_W'(m2_pyh_ff) << LO_W) + ACC_W'(m2_pyl_ff)
                 + (ACC_W'(1) << (2*F - 1));
      m3_mx_in = xacc[2*F +: POS_W];
      m3_my_in = yacc[2*F +: POS_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
         m2_vld_ff <= 1'b0;
         m3_vld_ff <= 1'b0;
      end else if (en) begin
         m1_vld_ff <= side_vld_ff[TRIG_LAT-1];
         m2_vld_ff <= m1_vld_ff;
         m3_vld_ff <= m2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_rce_ff  <= m1_rce_in;
         m1_rse_ff  <= m1_rse_in;
         m1_sa_ff   <= m1_sa_in;
         m1_ca_ff   <= m1_ca_in;
         m1_sign_ff <= side_out.sign;
         m2_pxl_ff  <= m2_pxl_in;
         m2_pxh_ff  <= m2_pxh_in;
         m2_pyl_ff  <= m2_pyl_in;
         m2_pyh_ff  <= m2_pyh_in;
         m2_mz_ff   <= m2_mz_in;
         m2_sign_ff <= m1_sign_ff;
         m3_mx_ff   <= m3_mx_in;
         m3_my_ff   <= m3_my_in;
         m3_mz_ff   <= m2_mz_ff;
         m3_sign_ff <= m2_sign_ff;
      end
   end

   // ---- output: apply signs, a zero magnitude stays positive ----
   always_comb begin
      rsp_pos_x_in = (m3_sign_ff.sneg && m3_mx_ff != '0) ? -signed'(m3_mx_ff)
                                                         : signed'(m3_mx_ff);
      rsp_pos_y_in = (m3_sign_ff.cneg && m3_my_ff != '0) ? -signed'(m3_my_ff)
                                                         : signed'(m3_my_ff);
      rsp_pos_z_in = (m3_sign_ff.eneg && m3_mz_ff != '0) ? -signed'(m3_mz_ff)
                                                         : signed'(m3_mz_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= m3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_pos_x_ff <= rsp_pos_x_in;
         rsp_pos_y_ff <= rsp_pos_y_in;
         rsp_pos_z_ff <= rsp_pos_z_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = rsp_pos_x_ff;
   assign rsp_pos_y = rsp_pos_y_ff;
   assign rsp_pos_z = rsp_pos_z_ff;

endmodule

/* design/lrc_checker.sv */
// ----------------------------------------------------------------------------
// lrc_checker: port-level checks for lidar_return_to_cartesian
// Watches the request and response channels and flags handshake or range
// slips; attached to the top level by bind.
// ----------------------------------------------------------------------------
module lrc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic        [lrc_pkg::BEAM_W-1:0]   req_beam_index,
   input logic        [lrc_pkg::DIST_W-1:0]   req_distance,
   input logic        [lrc_pkg::AZ_W-1:0]     req_azimuth_cdeg,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [lrc_pkg::POS_W-1:0]    rsp_pos_x,
   input logic signed [lrc_pkg::POS_W-1:0]    rsp_pos_y,
   input logic signed [lrc_pkg::POS_W-1:0]    rsp_pos_z
);

   localparam logic [lrc_pkg::POS_W-1:0] MOST_NEG = {1'b1, {(lrc_pkg::POS_W-1){1'b0}}};

   // a held word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pos_x)
                                 && $stable(rsp_pos_y) && $stable(rsp_pos_z))
      else $error("response word changed while stalled");

   // a stalled request word stays put
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_beam_index)
                                 && $stable(req_distance) && $stable(req_azimuth_cdeg))
      else $error("request word changed while stalled");

   // input backs up only behind a held output word
   a_req_stall_src: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("req_stall does not follow the held output word");

   a_empty_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // magnitudes never exceed the range field
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pos_x != MOST_NEG && rsp_pos_y != MOST_NEG
                    && rsp_pos_z != MOST_NEG)
      else $error("coordinate out of range");

endmodule

bind lidar_return_to_cartesian lrc_checker u_lrc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_beam_index   (req_beam_index),
   .req_distance     (req_distance),
   .req_azimuth_cdeg (req_azimuth_cdeg),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_pos_x        (rsp_pos_x),
   .rsp_pos_y        (rsp_pos_y),
   .rsp_pos_z        (rsp_pos_z)
);

/* test/lidar_return_to_cartesian_test.sv */
// ----------------------------------------------------------------------------
// lidar_return_to_cartesian_test: point check for the lidar return converter
// Sends returns over every beam, range extreme and azimuth quadrant, then
// long random runs with random idle on both channels. A scoreboard projects
// each accepted return to an x, y, z point in its own fixed-point arithmetic
// and compares each delivered point against the oldest projection.
// ----------------------------------------------------------------------------
module lidar_return_to_cartesian_test;

   localparam int CYCLE_LIMIT = 1000;
   localparam int MAX_GAP     = 17;
   localparam int TAIL_CYCLES = 40;

   typedef struct {
      logic signed [lrc_pkg::POS_W-1:0] x;
      logic signed [lrc_pkg::POS_W-1:0] y;
      logic signed [lrc_pkg::POS_W-1:0] z;
   } point_type;

   class point_board;
      localparam int     FRAC       = 16;
      localparam longint Q30_ONE    = 64'sd1 << 30;
      localparam longint RAD_PI_Q30 = 64'sd3373259426;

      point_type   points_due[$];
      int unsigned mismatches = 0;

      // odd beams point up by their index in degrees, even beams down by 15 - index
      function int beam_elevation(logic [3:0] b);
         return b[0] ? int'(b) : int'(b) - 15;
      endfunction

      function longint to_frac(longint v);
         if (v < 0) v = 0;
         if (v > Q30_ONE) v = Q30_ONE;
         return (v + (64'sd1 << (29 - FRAC))) >> (30 - FRAC);
      endfunction

      // a in 0..4500 centidegrees: truncated Taylor series in Q30
      function void octant_sin_cos(input int a, output longint s, output longint c);
         longint t, t2, term, acc;
         int     k;
         t = (longint'(a) * RAD_PI_Q30 + 9000) / 18000;
         t2 = (t * t) >> 30;
         term = t;
         acc = t;
         for (k = 1; k <= 4; k++) begin
            term = ((term * t2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) acc -= term; else acc += term;
         end
         s = to_frac(acc);
         term = Q30_ONE;
         acc = Q30_ONE;
         for (k = 1; k <= 5; k++) begin
            term = ((term * t2) >> 30) / longint'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) acc -= term; else acc += term;
         end
         c = to_frac(acc);
      endfunction

      function void quarter_sin_cos(input int a, output longint s, output longint c);
         if (a <= 4500) octant_sin_cos(a, s, c);
         else octant_sin_cos(9000 - a, c, s);
      endfunction

      function point_type project_return(logic [7:0] beam, logic [15:0] distance,
                                         logic [15:0] az);
         point_type p;
         int        el, az_wrap;
         longint    se, ce, rs, rc, sa, ca, mx, my, mz;
         bit        sa_neg, ca_neg;
         el = beam_elevation(beam[3:0]);
         quarter_sin_cos((el < 0 ? -el : el) * 100, se, ce);
         az_wrap = int'(az) % 36000;
         quarter_sin_cos(az_wrap % 9000, rs, rc);
         case (az_wrap / 9000)
            0: begin sa = rs; sa_neg = 1'b0; ca = rc; ca_neg = 1'b0; end
            1: begin sa = rc; sa_neg = 1'b0; ca = rs; ca_neg = 1'b1; end
            2: begin sa = rs; sa_neg = 1'b1; ca = rc; ca_neg = 1'b1; end
            default: begin sa = rc; sa_neg = 1'b1; ca = rs; ca_neg = 1'b0; end
         endcase
         mx = (longint'(distance) * ce * sa + (64'sd1 << (2 * FRAC - 1))) >> (2 * FRAC);
         my = (longint'(distance) * ce * ca + (64'sd1 << (2 * FRAC - 1))) >> (2 * FRAC);
         mz = (longint'(distance) * se + (64'sd1 << (FRAC - 1))) >> FRAC;
         p.x = lrc_pkg::POS_W'(sa_neg ? -mx : mx);
         p.y = lrc_pkg::POS_W'(ca_neg ? -my : my);
         p.z = lrc_pkg::POS_W'(el < 0 ? -mz : mz);
         return p;
      endfunction

      function void note_return(logic [7:0] beam, logic [15:0] distance, logic [15:0] az);
         points_due.push_back(project_return(beam, distance, az));
      endfunction

      function void flag(string what, point_type want, point_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("%s: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                     what, want.x, want.y, want.z, got.x, got.y, got.z);
      endfunction

      function void check_point(point_type got);
         point_type want;
         if (points_due.size() == 0) begin
            want = '{x: 'x, y: 'x, z: 'x};
            flag("point with no return pending", want, got);
         end else begin
            want = points_due.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z)
               flag("point mismatch", want, got);
         end
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic        [lrc_pkg::BEAM_W-1:0]   req_beam_index = '0;
   logic        [lrc_pkg::DIST_W-1:0]   req_distance = '0;
   logic        [lrc_pkg::AZ_W-1:0]     req_azimuth_cdeg = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic signed [lrc_pkg::POS_W-1:0]    rsp_pos_x;
   logic signed [lrc_pkg::POS_W-1:0]    rsp_pos_y;
   logic signed [lrc_pkg::POS_W-1:0]    rsp_pos_z;

   point_board  board = new();
   bit          calm = 1'b0;
   int unsigned returns_sent = 0;
   int unsigned points_seen = 0;
   int unsigned quiet_cycles = 0;

   lidar_return_to_cartesian dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_beam_index   (req_beam_index),
      .req_distance     (req_distance),
      .req_azimuth_cdeg (req_azimuth_cdeg),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_pos_z        (rsp_pos_z)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int unsigned draw_gap();
      return calm ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // check the point leaving at this edge before noting the return entering
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            board.check_point('{x: rsp_pos_x, y: rsp_pos_y, z: rsp_pos_z});
            points_seen++;
         end
         if (req_valid && !req_stall) begin
            board.note_return(req_beam_index, req_distance, req_azimuth_cdeg);
            returns_sent++;
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= CYCLE_LIMIT) begin
               $display("no word moved for %0d cycles", CYCLE_LIMIT);
               $display("status: fail");
               $finish;
            end
         end
      end
   end

   // point side: hold stall for a drawn number of cycles, then take one word
   initial begin
      int unsigned gap;
      wait (reset == 1'b0);
      forever begin
         gap = draw_gap();
         repeat (gap) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_return(input logic [7:0] beam, input logic [15:0] distance,
                              input logic [15:0] az);
      int unsigned gap;
      gap = draw_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_beam_index   <= beam;
      req_distance     <= distance;
      req_azimuth_cdeg <= az;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_random();
      int unsigned pick;
      int          az;
      logic [15:0] distance;
      pick = $urandom_range(0, 15);
      if (pick == 10) distance = 16'($urandom_range(0, 8));
      else if (pick == 11) distance = 16'hFFFF;
      else if (pick == 12) distance = '0;
      else distance = 16'($urandom_range(0, 65535));
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         az = $urandom_range(0, 35999);
      end else if (pick == 7) begin
         // land within a few centidegrees of an octant boundary
         az = $urandom_range(0, 8) * 4500 + $urandom_range(0, 6) - 3;
         if (az < 0) az += 36000;
      end else if (pick == 8) begin
         az = $urandom_range(0, 65535);
      end else begin
         az = $urandom_range(35995, 36005);
      end
      send_return(8'($urandom_range(0, 255)), distance, 16'(az));
   endtask

   task automatic wait_points_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.points_due.size() != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned k, phase;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every beam at full range, sweeping the azimuth in sixteenth turns
      for (k = 0; k < 16; k++) send_return(8'(k), 16'hFFFF, 16'(k * 2250));
      send_return(8'hFF, 16'hFFFF, 16'd35999);
      send_return(8'hF0, 16'd0, 16'hFFFF);
      send_return(8'hA5, 16'hFFFF, 16'd36000);
      send_return(8'h5A, 16'd1, 16'd4499);
      send_return(8'h3C, 16'hFFFF, 16'd4501);
      send_return(8'hC3, 16'h8000, 16'd8999);
      wait_points_drained();

      for (phase = 0; phase < 6; phase++) begin
         calm = (phase % 3 == 1);
         repeat (300) send_random();
         wait_points_drained();
      end
      calm = 1'b0;
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d returns and %0d points: all beams, range extremes, every quadrant",
               returns_sent, points_seen);
      $display("and azimuth wrap, with random and back-to-back idle; %0d mismatches",
               board.mismatches);
      if (board.mismatches == 0 && board.points_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
